FILE: hw/rtl/h2r_pkg.sv
// Package for the HSL to RGB converter: field widths, pipeline depth and arithmetic constants.
// It depends on nothing; the converter core takes its names by scoped reference.
package h2r_pkg;

	// Fixed widths of the channel fields.
	localparam int HueW   = 16;
	localparam int PctInW = 8;
	localparam int LevelW = 8;

	// Internal widths.
	localparam int PctW   = 7;   // clamped percent, 0..100
	localparam int AngW   = 9;   // reduced hue, 0..359
	localparam int FracW  = 6;   // ramp position, 0..60
	localparam int HelpW  = 14;  // helper levels at a scale of 10000
	localparam int RampW  = 20;  // ramp value, at most 600000
	localparam int WideW  = 28;  // ramp times 255
	localparam int RecW   = 21;  // width of the level reciprocal
	localparam int ProdW  = RampW + RecW;

	localparam int Lanes  = 3;   // red, green, blue
	localparam int Stages = 9;

	// Arithmetic constants.
	localparam int HueMod      = 360;
	localparam int PctMax      = 100;
	localparam int LevelMax    = 255;
	localparam int RampScale   = 600000;
	localparam int LigHalf     = 50;
	localparam int LigTwice    = 200;
	localparam int Sector      = 60;
	localparam int ThirdTurn   = 120;
	localparam int FullRise    = 180;
	localparam int TwoThirds   = 240;

	// floor(hue / 360) is estimated as (hue * 182) >> 16; the estimate is low by at most one.
	localparam int HueRecip    = 182;
	localparam int HueShift    = 16;

	// floor(ramp * 255 / 600000) is estimated as (ramp * LevelRecip) >> 32,
	// again low by at most one.
	localparam int LevelRecip  = 1825361;
	localparam int LevelShift  = 32;

	typedef logic [PctW-1:0]   pct_t;
	typedef logic [AngW-1:0]   ang_t;
	typedef logic [FracW-1:0]  frac_t;
	typedef logic [HelpW-1:0]  help_t;
	typedef logic [RampW-1:0]  ramp_t;
	typedef logic [WideW-1:0]  wide_t;
	typedef logic [LevelW-1:0] level_t;

endpackage

FILE: hw/rtl/hsl_to_rgb_converter_core.sv
// HSL to RGB converter core: a nine-stage pipeline from hue, saturation and lightness to 8-bit RGB.
// It depends on h2r_pkg for widths and constants.
//
//   Channel   Direction  Handshake              Payload
//   hsl       in         hsl_valid/hsl_ready    hue_degrees, saturation_pct, lightness_pct
//   rgb       out        rgb_valid/rgb_ready    red_level, green_level, blue_level
//
// One beat enters per clock cycle while rgb_ready does not stall the output; its result
// passes through the nine register stages of the arithmetic, and no loop holds a beat back.
// Every stage holds a valid bit; a stage takes new data whenever it is empty or the
// stage after it moves, so bubbles close up and input is accepted while a result waits.
// A stall on rgb_ready holds every full stage with no empty stage after it, so nothing is dropped or repeated.
// The asynchronous reset arst_n clears the valid bits only; the data registers are not reset.
module hsl_to_rgb_converter_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          hsl_valid,
	output logic                          hsl_ready,
	input  logic [h2r_pkg::HueW-1:0]      hue_degrees,
	input  logic [h2r_pkg::PctInW-1:0]    saturation_pct,
	input  logic [h2r_pkg::PctInW-1:0]    lightness_pct,
	output logic                          rgb_valid,
	input  logic                          rgb_ready,
	output logic [h2r_pkg::LevelW-1:0]    red_level,
	output logic [h2r_pkg::LevelW-1:0]    green_level,
	output logic [h2r_pkg::LevelW-1:0]    blue_level
);

	localparam int NS = h2r_pkg::Stages;
	localparam int NL = h2r_pkg::Lanes;

	// Valid bit of each stage and the load enable that each stage derives from the next.
	logic [NS:1]   vld_q;
	logic [NS+1:1] en;

	always_comb begin
		en[NS+1] = rgb_ready;
		for (int i = NS; i >= 1; i--) begin
			en[i] = !vld_q[i] || en[i+1];
		end
	end

	assign hsl_ready = en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1]) begin
				vld_q[1] <= hsl_valid;
			end
			for (int i = 2; i <= NS; i++) begin
				if (en[i]) begin
					vld_q[i] <= vld_q[i-1];
				end
			end
		end
	end

	// Stage 1: clamp the percentages and estimate the number of whole turns in the hue.
	h2r_pkg::pct_t                  sat_c, lig_c;
	logic [h2r_pkg::HueW+7:0]       hue_x;
	logic [h2r_pkg::HueW-1:0]       hue_s1;
	logic [7:0]                     turns_s1;
	h2r_pkg::pct_t                  sat_s1, lig_s1;

	assign sat_c = (saturation_pct > h2r_pkg::PctInW'(h2r_pkg::PctMax)) ?
		h2r_pkg::PctW'(h2r_pkg::PctMax) : saturation_pct[h2r_pkg::PctW-1:0];
	assign lig_c = (lightness_pct > h2r_pkg::PctInW'(h2r_pkg::PctMax)) ?
		h2r_pkg::PctW'(h2r_pkg::PctMax) : lightness_pct[h2r_pkg::PctW-1:0];
	assign hue_x = (h2r_pkg::HueW+8)'(hue_degrees) * (h2r_pkg::HueW+8)'(h2r_pkg::HueRecip);

	// Stage 2: partial remainder of the hue (below 720) and the high helper level.
	logic [16:0]                    hrem_full;
	logic [14:0]                    high_lo, high_hi;
	logic [7:0]                     ls_sum;
	logic [9:0]                     hrem_s2;
	h2r_pkg::help_t                 high_s2;
	h2r_pkg::pct_t                  lig_s2;

	assign hrem_full = 17'(hue_s1) - 17'(turns_s1) * 17'(h2r_pkg::HueMod);
	assign ls_sum    = 8'(sat_s1) + 8'(lig_s1);
	assign high_lo   = 15'(lig_s1) * (15'(sat_s1) + 15'(h2r_pkg::PctMax));
	assign high_hi   = 15'(ls_sum) * 15'(h2r_pkg::PctMax) - 15'(sat_s1) * 15'(lig_s1);

	// Stage 3: final hue reduction; low helper level and the rise between the two.
	// Zero saturation needs no branch of its own: high and low both become lightness*100,
	// so every ramp is flat at lightness*6000 and scales to lightness*255/100.
	logic [14:0]                    low_full, rise_full;
	h2r_pkg::ang_t                  hue_s3;
	h2r_pkg::help_t                 low_s3, rise_s3;

	assign low_full  = 15'(lig_s2) * 15'(h2r_pkg::LigTwice) - 15'(high_s2);
	assign rise_full = {high_s2, 1'b0} - 15'(lig_s2) * 15'(h2r_pkg::LigTwice);

	// Stage 4: per-lane hue angle and position on the piecewise ramp.
	h2r_pkg::ang_t                  ang [NL];
	h2r_pkg::frac_t                 pos [NL];
	h2r_pkg::frac_t                 pos_s4 [NL];
	h2r_pkg::ramp_t                 base_s4;
	h2r_pkg::help_t                 rise_s4;

	always_comb begin
		// Red leads by a third of a turn, green uses the hue, blue trails by a third.
		ang[0] = (hue_s3 < h2r_pkg::AngW'(h2r_pkg::TwoThirds)) ?
			hue_s3 + h2r_pkg::AngW'(h2r_pkg::ThirdTurn) :
			hue_s3 - h2r_pkg::AngW'(h2r_pkg::TwoThirds);
		ang[1] = hue_s3;
		ang[2] = (hue_s3 >= h2r_pkg::AngW'(h2r_pkg::ThirdTurn)) ?
			hue_s3 - h2r_pkg::AngW'(h2r_pkg::ThirdTurn) :
			hue_s3 + h2r_pkg::AngW'(h2r_pkg::TwoThirds);
		for (int l = 0; l < NL; l++) begin
			if (ang[l] < h2r_pkg::AngW'(h2r_pkg::Sector)) begin
				pos[l] = ang[l][h2r_pkg::FracW-1:0];
			end else if (ang[l] < h2r_pkg::AngW'(h2r_pkg::FullRise)) begin
				pos[l] = h2r_pkg::FracW'(h2r_pkg::Sector);
			end else if (ang[l] < h2r_pkg::AngW'(h2r_pkg::TwoThirds)) begin
				pos[l] = h2r_pkg::FracW'(h2r_pkg::AngW'(h2r_pkg::TwoThirds) - ang[l]);
			end else begin
				pos[l] = '0;
			end
		end
	end

	// Stage 5: rise times ramp position.  Stage 6: ramp value.
	h2r_pkg::ramp_t                 slope_s5 [NL];
	h2r_pkg::ramp_t                 base_s5;
	h2r_pkg::ramp_t                 ramp_s6 [NL];

	// Stage 7: level estimate by reciprocal, and the exact numerator ramp*255.
	logic [h2r_pkg::ProdW-1:0]      est [NL];
	h2r_pkg::level_t                qe_s7 [NL];
	h2r_pkg::wide_t                 num_s7 [NL];

	// Stage 8: estimate times the divisor.  Stage 9: one-step correction of the estimate.
	h2r_pkg::level_t                qe_s8 [NL];
	h2r_pkg::wide_t                 num_s8 [NL];
	h2r_pkg::wide_t                 back_s8 [NL];
	h2r_pkg::level_t                lvl_s9 [NL];
	h2r_pkg::wide_t                 rem [NL];

	always_comb begin
		for (int l = 0; l < NL; l++) begin
			est[l] = h2r_pkg::ProdW'(ramp_s6[l]) * h2r_pkg::ProdW'(h2r_pkg::LevelRecip);
			rem[l] = num_s8[l] - back_s8[l];
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			hue_s1   <= hue_degrees;
			turns_s1 <= hue_x[h2r_pkg::HueShift +: 8];
			sat_s1   <= sat_c;
			lig_s1   <= lig_c;
		end
		if (en[2]) begin
			hrem_s2 <= hrem_full[9:0];
			high_s2 <= (lig_s1 < h2r_pkg::PctW'(h2r_pkg::LigHalf)) ?
				high_lo[h2r_pkg::HelpW-1:0] : high_hi[h2r_pkg::HelpW-1:0];
			lig_s2  <= lig_s1;
		end
		if (en[3]) begin
			hue_s3  <= (hrem_s2 >= 10'(h2r_pkg::HueMod)) ?
				h2r_pkg::AngW'(hrem_s2 - 10'(h2r_pkg::HueMod)) : hrem_s2[h2r_pkg::AngW-1:0];
			low_s3  <= low_full[h2r_pkg::HelpW-1:0];
			rise_s3 <= rise_full[h2r_pkg::HelpW-1:0];
		end
		if (en[4]) begin
			pos_s4  <= pos;
			base_s4 <= h2r_pkg::RampW'(low_s3) * h2r_pkg::RampW'(h2r_pkg::Sector);
			rise_s4 <= rise_s3;
		end
		if (en[5]) begin
			for (int l = 0; l < NL; l++) begin
				slope_s5[l] <= h2r_pkg::RampW'(rise_s4) * h2r_pkg::RampW'(pos_s4[l]);
			end
			base_s5 <= base_s4;
		end
		if (en[6]) begin
			for (int l = 0; l < NL; l++) begin
				ramp_s6[l] <= base_s5 + slope_s5[l];
			end
		end
		if (en[7]) begin
			for (int l = 0; l < NL; l++) begin
				qe_s7[l]  <= est[l][h2r_pkg::LevelShift +: h2r_pkg::LevelW];
				num_s7[l] <= h2r_pkg::WideW'(ramp_s6[l]) * h2r_pkg::WideW'(h2r_pkg::LevelMax);
			end
		end
		if (en[8]) begin
			for (int l = 0; l < NL; l++) begin
				qe_s8[l]   <= qe_s7[l];
				num_s8[l]  <= num_s7[l];
				back_s8[l] <= h2r_pkg::WideW'(qe_s7[l]) * h2r_pkg::WideW'(h2r_pkg::RampScale);
			end
		end
		if (en[9]) begin
			for (int l = 0; l < NL; l++) begin
				lvl_s9[l] <= (rem[l] >= h2r_pkg::WideW'(h2r_pkg::RampScale)) ?
					qe_s8[l] + h2r_pkg::LevelW'(1) : qe_s8[l];
			end
		end
	end

	assign rgb_valid   = vld_q[NS];
	assign red_level   = lvl_s9[0];
	assign green_level = lvl_s9[1];
	assign blue_level  = lvl_s9[2];

`ifndef SYNTHESIS
	// The hue reduction must land in 0..359 after its single correction step.
	a_hue_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[3] |-> hue_s3 < h2r_pkg::AngW'(h2r_pkg::HueMod))
		else $error("hue reduction out of range");

	// The low helper level plus the rise, that is the high level, stays within 10000.
	a_low_below_high: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[3] |-> 15'(low_s3) + 15'(rise_s3) <= 15'(10000))
		else $error("helper levels out of range");

	// Every ramp value stays within full scale.
	a_ramp_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[6] |-> ramp_s6[0] <= h2r_pkg::RampW'(h2r_pkg::RampScale) &&
			ramp_s6[1] <= h2r_pkg::RampW'(h2r_pkg::RampScale) &&
			ramp_s6[2] <= h2r_pkg::RampW'(h2r_pkg::RampScale))
		else $error("ramp value above full scale");

	// The reciprocal estimate of the red lane is never high and at most one low.
	a_estimate_close: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[8] |-> num_s8[0] >= back_s8[0] &&
			rem[0] < h2r_pkg::WideW'(2 * h2r_pkg::RampScale))
		else $error("level estimate off by more than one");
`endif

endmodule

FILE: test/hsl_to_rgb_converter_core_tb.sv
// Self-checking testbench for the HSL to RGB converter core: directed table, then random beats.
// It depends on h2r_pkg and hsl_to_rgb_converter_core; it needs no other file.
module hsl_to_rgb_converter_core_tb;
	import h2r_pkg::*;

	// One color result, field for field as the rgb channel carries it.
	typedef struct packed {
		level_t red;
		level_t green;
		level_t blue;
	} rgb_t;

	// A row of the directed table. Where known is set, want holds a result that can be
	// read straight off the color math; otherwise the predictor supplies the result.
	typedef struct packed {
		logic [HueW-1:0]   hue;
		logic [PctInW-1:0] sat;
		logic [PctInW-1:0] lig;
		logic              known;
		rgb_t              want;
	} hsl_row_t;

	localparam rgb_t Black   = '{8'd0, 8'd0, 8'd0};
	localparam rgb_t White   = '{8'd255, 8'd255, 8'd255};
	localparam rgb_t Gray50  = '{8'd127, 8'd127, 8'd127};
	localparam rgb_t Red     = '{8'd255, 8'd0, 8'd0};
	localparam rgb_t Yellow  = '{8'd255, 8'd255, 8'd0};
	localparam rgb_t Green   = '{8'd0, 8'd255, 8'd0};
	localparam rgb_t Blue    = '{8'd0, 8'd0, 8'd255};

	localparam int DirectedRows = 23;
	localparam int RandomBeats  = 1750;
	localparam int HoldCycles   = 80;    // long receiver hold-off that backs up the pipeline
	localparam int HoldAt       = 400;   // hsl beat count at which that hold-off starts
	localparam int QuietFrom    = 800;   // no idling on either side in [QuietFrom, QuietTo)
	localparam int QuietTo      = 1100;
	localparam int DrainAt      = 1300;  // random beat before which the sender drains the pipe
	localparam int StallLimit   = 1000;  // cycles without any beat before the run is abandoned

	hsl_row_t directed_rows [DirectedRows] = '{
		'{16'd0,     8'd0,   8'd0,   1'b1, Black},   // black gray
		'{16'd0,     8'd0,   8'd100, 1'b1, White},   // white gray
		'{16'd0,     8'd0,   8'd50,  1'b1, Gray50},  // mid gray truncates to 127
		'{16'd0,     8'd0,   8'd255, 1'b1, White},   // lightness clamps to 100 on the gray path
		'{16'd200,   8'd0,   8'd37,  1'b0, Black},   // gray ignores the hue
		'{16'd0,     8'd100, 8'd50,  1'b1, Red},
		'{16'd60,    8'd100, 8'd50,  1'b1, Yellow},
		'{16'd120,   8'd100, 8'd50,  1'b1, Green},
		'{16'd240,   8'd100, 8'd50,  1'b1, Blue},
		'{16'd360,   8'd100, 8'd50,  1'b1, Red},     // hue wraps at a full turn
		'{16'd65535, 8'd100, 8'd50,  1'b0, Black},   // largest hue, wraps to 15 degrees
		'{16'd0,     8'd255, 8'd50,  1'b1, Red},     // saturation clamps to 100
		'{16'd0,     8'd100, 8'd0,   1'b1, Black},
		'{16'd0,     8'd100, 8'd100, 1'b1, White},
		'{16'd180,   8'd255, 8'd255, 1'b1, White},   // both percents clamp
		'{16'd300,   8'd100, 8'd50,  1'b0, Black},
		'{16'd59,    8'd50,  8'd49,  1'b0, Black},   // just below half lightness
		'{16'd61,    8'd1,   8'd51,  1'b0, Black},   // just above half lightness
		'{16'd179,   8'd77,  8'd23,  1'b0, Black},
		'{16'd239,   8'd33,  8'd90,  1'b0, Black},
		'{16'd719,   8'd100, 8'd75,  1'b0, Black},
		'{16'd65535, 8'd255, 8'd255, 1'b1, White},   // every input bit high
		'{16'd359,   8'd1,   8'd1,   1'b0, Black}
	};

	// Hue angles around the sector edges of the ramp, and percents around its corners.
	int unsigned hue_edges [16] = '{0, 59, 60, 61, 119, 120, 121, 179,
	                                180, 181, 239, 240, 241, 299, 300, 359};
	int unsigned sat_edges [5]  = '{1, 2, 99, 100, 101};
	int unsigned lig_edges [7]  = '{0, 1, 49, 50, 51, 100, 101};

	logic                clk;
	logic                arst_n;
	logic                hsl_valid;
	logic                hsl_ready;
	logic [HueW-1:0]     hue_degrees;
	logic [PctInW-1:0]   saturation_pct;
	logic [PctInW-1:0]   lightness_pct;
	logic                rgb_valid;
	logic                rgb_ready;
	level_t              red_level;
	level_t              green_level;
	level_t              blue_level;

	// Typed result that travels with a directed beat; the monitor uses it instead of
	// the predictor whenever typed_known is set at acceptance.
	logic                typed_known;
	rgb_t                typed_rgb;

	rgb_t                rgb_pending [$];
	int unsigned         hsl_beats;
	int unsigned         rgb_beats;
	int unsigned         gray_beats;
	int unsigned         mismatch_count;
	int unsigned         idle_cycles;
	bit                  hold_done;

	hsl_to_rgb_converter_core dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.hsl_valid      (hsl_valid),
		.hsl_ready      (hsl_ready),
		.hue_degrees    (hue_degrees),
		.saturation_pct (saturation_pct),
		.lightness_pct  (lightness_pct),
		.rgb_valid      (rgb_valid),
		.rgb_ready      (rgb_ready),
		.red_level      (red_level),
		.green_level    (green_level),
		.blue_level     (blue_level)
	);

	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// One channel of the hue ramp: rises over the first sector, holds at the high helper
	// level up to 180 degrees, falls back until 240 degrees and rests at the low level.
	// The ramp is kept at a scale of 600000 and brought down to eight bits by truncation.
	function automatic level_t ramp_level(input int unsigned low, input int unsigned high,
			input int unsigned ang);
		int unsigned ramp;
		if (ang < Sector) begin
			ramp = low * Sector + (high - low) * ang;
		end else if (ang < FullRise) begin
			ramp = high * Sector;
		end else if (ang < TwoThirds) begin
			ramp = low * Sector + (high - low) * (TwoThirds - ang);
		end else begin
			ramp = low * Sector;
		end
		return level_t'(ramp * LevelMax / RampScale);
	endfunction

	// Color that the core must give for one hsl beat.
	function automatic rgb_t predict_rgb(input logic [HueW-1:0] hue_in,
			input logic [PctInW-1:0] sat_in, input logic [PctInW-1:0] lig_in);
		int unsigned ang;
		int unsigned sat;
		int unsigned lig;
		int unsigned high;
		int unsigned low;
		rgb_t        rgb;
		ang = hue_in % HueMod;
		sat = (sat_in > PctMax) ? PctMax : sat_in;
		lig = (lig_in > PctMax) ? PctMax : lig_in;
		if (sat == 0) begin
			rgb.red   = level_t'(lig * LevelMax / PctMax);
			rgb.green = rgb.red;
			rgb.blue  = rgb.red;
		end else begin
			// Helper levels at a scale of 10000; the upper one depends on which half of
			// the lightness range we are in, the lower one mirrors it around lightness.
			if (lig < LigHalf)
				high = lig * (PctMax + sat);
			else
				high = (lig + sat) * PctMax - sat * lig;
			low = lig * LigTwice - high;
			// Red leads the hue by a third of a turn, blue trails it by the same amount.
			rgb.red   = ramp_level(low, high,
				(ang < TwoThirds) ? ang + ThirdTurn : ang - TwoThirds);
			rgb.green = ramp_level(low, high, ang);
			rgb.blue  = ramp_level(low, high,
				(ang >= ThirdTurn) ? ang - ThirdTurn : ang + TwoThirds);
		end
		return rgb;
	endfunction

	// Both sides stop idling for a stretch so that the pipeline runs at full rate.
	function automatic bit quiet_stretch();
		return hsl_beats >= QuietFrom && hsl_beats < QuietTo;
	endfunction

	// Offer one hsl beat and return at the edge where it is accepted. A random idle gap
	// may come first; valid is lowered only in the step where the previous beat left.
	task automatic send_hsl(input logic [HueW-1:0] hue, input logic [PctInW-1:0] sat,
			input logic [PctInW-1:0] lig, input logic known, input rgb_t want);
		if (!quiet_stretch() && $urandom_range(99) < 25) begin
			hsl_valid <= 1'b0;
			@(posedge clk);
		end
		hsl_valid      <= 1'b1;
		hue_degrees    <= hue;
		saturation_pct <= sat;
		lightness_pct  <= lig;
		typed_known    <= known;
		typed_rgb      <= want;
		do @(posedge clk); while (!hsl_ready);
	endtask

	// Monitor. All sampling happens right at the rising edge, before the nonblocking updates
	// of that edge, so it sees exactly the values that the core sees. The rgb side is
	// checked before the hsl side is recorded; with a nine-stage pipeline the two never
	// refer to the same beat anyway.
	always @(posedge clk) begin
		rgb_t got;
		rgb_t want;
		if (rgb_valid && rgb_ready) begin
			got = '{red_level, green_level, blue_level};
			rgb_beats++;
			if (rgb_pending.size() == 0) begin
				$error("rgb beat with no hsl beat outstanding: %0d %0d %0d",
					got.red, got.green, got.blue);
				mismatch_count++;
			end else begin
				want = rgb_pending.pop_front();
				if (got.red !== want.red) begin
					$error("red_level: expected %0d, got %0d", want.red, got.red);
					mismatch_count++;
				end
				if (got.green !== want.green) begin
					$error("green_level: expected %0d, got %0d", want.green, got.green);
					mismatch_count++;
				end
				if (got.blue !== want.blue) begin
					$error("blue_level: expected %0d, got %0d", want.blue, got.blue);
					mismatch_count++;
				end
			end
		end
		if (hsl_valid && hsl_ready) begin
			hsl_beats++;
			if (saturation_pct == 0)
				gray_beats++;
			if (typed_known)
				rgb_pending.push_back(typed_rgb);
			else
				rgb_pending.push_back(predict_rgb(hue_degrees, saturation_pct, lightness_pct));
		end
		// Watchdog: any beat on either side counts as progress.
		if ((hsl_valid && hsl_ready) || (rgb_valid && rgb_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= StallLimit) begin
			$display("timeout: %0d cycles without a beat, %0d results outstanding",
				idle_cycles, rgb_pending.size());
			$display("hsl_to_rgb_converter_core_tb: errors");
			$finish;
		end
	end

	// Receiver. It drops ready in about one cycle in five, except in the quiet stretch,
	// and once holds it low for a long run so that every stage fills and hsl_ready falls
	// while the sender keeps offering beats.
	initial begin
		rgb_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!hold_done && hsl_beats >= HoldAt) begin
				hold_done = 1'b1;
				rgb_ready <= 1'b0;
				repeat (HoldCycles - 1) @(posedge clk);
			end else begin
				rgb_ready <= quiet_stretch() || ($urandom_range(99) >= 20);
			end
		end
	end

	// Sender and run control.
	initial begin
		logic [HueW-1:0]   hue;
		logic [PctInW-1:0] sat;
		logic [PctInW-1:0] lig;
		arst_n         = 1'b0;
		hsl_valid      = 1'b0;
		hue_degrees    = '0;
		saturation_pct = '0;
		lightness_pct  = '0;
		typed_known    = 1'b0;
		typed_rgb      = Black;
		hsl_beats      = 0;
		rgb_beats      = 0;
		gray_beats     = 0;
		mismatch_count = 0;
		idle_cycles    = 0;
		hold_done      = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table: extremes, the primary colors, yellow and magenta, wrap and clamps.
		for (int i = 0; i < DirectedRows; i++)
			send_hsl(directed_rows[i].hue, directed_rows[i].sat, directed_rows[i].lig,
				directed_rows[i].known, directed_rows[i].want);

		// Random beats. Half are in-range colors; the rest stress wrap, clamps, the gray
		// path and the sector edges of the ramp.
		for (int i = 0; i < RandomBeats; i++) begin
			if (i == DrainAt) begin
				// Let the pipeline run dry before going on.
				hsl_valid <= 1'b0;
				do @(posedge clk); while (rgb_pending.size() != 0);
			end
			case ($urandom_range(9))
				0, 1, 2, 3, 4: begin
					hue = HueW'($urandom_range(0, HueMod - 1));
					sat = PctInW'($urandom_range(1, PctMax));
					lig = PctInW'($urandom_range(0, PctMax));
				end
				5: begin
					hue = HueW'($urandom);
					sat = PctInW'($urandom);
					lig = PctInW'($urandom);
				end
				6: begin
					hue = HueW'($urandom);
					sat = '0;
					lig = PctInW'($urandom);
				end
				7: begin
					hue = HueW'(hue_edges[$urandom_range(15)] + HueMod * $urandom_range(0, 3));
					sat = PctInW'(sat_edges[$urandom_range(4)]);
					lig = PctInW'(lig_edges[$urandom_range(6)]);
				end
				default: begin
					hue = HueW'($urandom_range(0, 3 * HueMod - 1));
					sat = PctInW'($urandom_range(0, PctMax + 10));
					lig = PctInW'($urandom_range(0, PctMax + 10));
				end
			endcase
			send_hsl(hue, sat, lig, 1'b0, Black);
		end
		hsl_valid <= 1'b0;

		// Wait for the last results, then a little longer to catch any stray beat.
		do @(posedge clk); while (rgb_pending.size() != 0);
		repeat (2 * Stages + 4) @(posedge clk);
		if (rgb_pending.size() != 0) begin
			$error("rgb beats: expected %0d more, got none", rgb_pending.size());
			mismatch_count++;
		end

		$display("run covered %0d hsl beats (%0d on the gray path) and %0d rgb beats,",
			hsl_beats, gray_beats, rgb_beats);
		$display("with a %0d-cycle output hold-off, a full drain and a no-idle stretch",
			HoldCycles);
		if (mismatch_count == 0)
			$display("hsl_to_rgb_converter_core_tb: clean");
		else
			$display("hsl_to_rgb_converter_core_tb: errors");
		$finish;
	end

endmodule
